[hw/rtl/ohs_pkg.sv]
// Shared constants and types for the open-addressing hash set.
package ohs_pkg;

  // Width of slot positions, the active slot count and the element count.
  localparam int unsigned CountW = 9;

  // Request operation codes.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Slot marks kept next to each stored key.
  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_DELETED = 2'd1;
  localparam logic [1:0] MARK_FILLED  = 2'd2;

  // Result of the home-slot remainder unit.
  typedef struct packed {
    logic              done;
    logic [CountW-1:0] rem;
  } mod_res_t;

endpackage

[hw/rtl/ohs_mod.sv]
// Iterative remainder unit: key modulo the active slot count, four key bits per cycle.
module ohs_mod #(
  parameter int unsigned KEY_W = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [KEY_W-1:0]             dividend_i,
  input  logic [ohs_pkg::CountW-1:0]   divisor_i,
  output ohs_pkg::mod_res_t            res_o
);
  import ohs_pkg::*;

  localparam int unsigned Digits = (KEY_W + 3) / 4;
  localparam int unsigned PadW   = Digits * 4;
  localparam int unsigned CntW   = (Digits > 1) ? $clog2(Digits) : 1;

  logic [PadW-1:0]   sreg_q, sreg_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [CountW:0]   step_r;
  logic [CountW:0]   div_ext;

  // Four shift-and-reduce steps; the partial remainder stays below the divisor.
  always_comb begin
    div_ext = {1'b0, divisor_i};
    step_r  = {1'b0, rem_q};
    for (int k = 0; k < 4; k++) begin
      step_r = {step_r[CountW-1:0], sreg_q[PadW-1-k]};
      if (step_r >= div_ext) begin
        step_r = step_r - div_ext;
      end
    end
  end

  // Sequencing of the digit steps.
  always_comb begin
    sreg_d = sreg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    if (start_i) begin
      sreg_d = PadW'(dividend_i);
      cnt_d  = CntW'(Digits - 1);
      busy_d = 1'b1;
      rem_d  = '0;
    end else if (busy_q) begin
      sreg_d = sreg_q << 4;
      rem_d  = step_r[CountW-1:0];
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sreg_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rem_q  <= '0;
    end else begin
      sreg_q <= sreg_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
      rem_q  <= rem_d;
    end
  end

  assign res_o.done = done_q;
  assign res_o.rem  = rem_q;

endmodule

[hw/rtl/open_addressing_hash_set.sv]
// Open-addressing hash set with linear probing and deleted marks. Each item is an add, find or
// remove of a key; the home slot is the key modulo the active slot count, and the probe walks
// one slot per cycle through a single memory that holds each slot's mark and key (registered
// read). An item passes through the remainder unit, which retires four key bits per cycle, then
// the probe, where each probe is one memory read, and a final write-back step that writes back the
// slot and updates the count; an item with the unused operation code skips the remainder and
// the probe. After reset the block sweeps the memory to empty marks, one slot a cycle, before
// it takes the first item; the active slot register may be written at any time the block is
// idle. A finished result waits in an output register, and the block takes the next item
// meanwhile.
module open_addressing_hash_set #(
  parameter int unsigned TABLE_SIZE = 256,
  parameter int unsigned KEY_WIDTH  = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       active_slots_we_i,
  input  logic [ohs_pkg::CountW-1:0] active_slots_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 operation_i,
  input  logic [31:0]                key_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       found_o,
  output logic                       changed_o,
  output logic                       table_full_o,
  output logic [ohs_pkg::CountW-1:0] element_count_o
);
  import ohs_pkg::*;

  localparam int unsigned KeyW  = (KEY_WIDTH > 32) ? 32 : KEY_WIDTH;
  localparam int unsigned IdxW  = $clog2(TABLE_SIZE);
  localparam int unsigned Cap   = (TABLE_SIZE < 511) ? TABLE_SIZE : 511;
  localparam int unsigned WordW = 2 + KeyW;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MOD, S_EVAL, S_DONE} state_e;

  state_e            state_q, state_d;
  logic [CountW-1:0] active_q, active_d;
  logic [CountW-1:0] count_q, count_d;
  logic [1:0]        op_q, op_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [CountW-1:0] pos_q, pos_d;
  logic [CountW-1:0] probes_q, probes_d;
  logic              seen_q, seen_d;
  logic [CountW-1:0] del_q, del_d;
  logic              found_q, found_d;
  logic              have_q, have_d;
  logic [CountW-1:0] slot_q, slot_d;
  logic [IdxW-1:0]   clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  logic              out_found_q, out_found_d;
  logic              out_changed_q, out_changed_d;
  logic              out_full_q, out_full_d;
  logic [CountW-1:0] out_count_q, out_count_d;

  // Slot memory: mark in the top two bits, key below.
  logic [WordW-1:0]  mem_q [TABLE_SIZE];
  logic [WordW-1:0]  rdata_q;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [WordW-1:0]  mem_wdata;
  logic [IdxW-1:0]   mem_raddr;

  logic [CountW-1:0] n_eff;
  logic [1:0]        rd_mark;
  logic [KeyW-1:0]   rd_key;
  logic [CountW-1:0] pos_inc;
  logic [CountW-1:0] pos_next;
  logic [CountW-1:0] probes_inc;
  logic              stop;
  logic              load_out;
  logic              res_changed;
  logic              res_full;
  logic              mod_start;
  mod_res_t          mod_res;

  // Effective slot count: zero acts as one, large values clamp to the table.
  always_comb begin
    if (active_q == '0) begin
      n_eff = CountW'(1);
    end else if (active_q > CountW'(Cap)) begin
      n_eff = CountW'(Cap);
    end else begin
      n_eff = active_q;
    end
  end

  // Home slot remainder unit.
  ohs_mod #(
    .KEY_W(KeyW)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .dividend_i(key_i[KeyW-1:0]),
    .divisor_i (n_eff),
    .res_o     (mod_res)
  );

  assign rd_mark    = rdata_q[WordW-1 -: 2];
  assign rd_key     = rdata_q[KeyW-1:0];
  assign pos_inc    = pos_q + 1'b1;
  assign pos_next   = (pos_inc == n_eff) ? '0 : pos_inc;
  assign probes_inc = probes_q + 1'b1;
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Request sequencing, probe evaluation and write-back.
  always_comb begin
    state_d       = state_q;
    active_d      = active_slots_we_i ? active_slots_i : active_q;
    count_d       = count_q;
    op_d          = op_q;
    key_d         = key_q;
    pos_d         = pos_q;
    probes_d      = probes_q;
    seen_d        = seen_q;
    del_d         = del_q;
    found_d       = found_q;
    have_d        = have_q;
    slot_d        = slot_q;
    clr_d         = clr_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_found_d   = out_found_q;
    out_changed_d = out_changed_q;
    out_full_d    = out_full_q;
    out_count_d   = out_count_q;
    in_ready_o    = 1'b0;
    mod_start     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = IdxW'(slot_q);
    mem_wdata     = {MARK_FILLED, key_q};
    mem_raddr     = IdxW'(pos_q);
    stop          = 1'b0;
    res_changed   = 1'b0;
    res_full      = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = {MARK_EMPTY, KeyW'(0)};
        clr_d     = clr_q + 1'b1;
        if (clr_q == IdxW'(TABLE_SIZE - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d     = operation_i;
          key_d    = key_i[KeyW-1:0];
          probes_d = '0;
          seen_d   = 1'b0;
          del_d    = '0;
          found_d  = 1'b0;
          have_d   = 1'b0;
          slot_d   = '0;
          case (operation_i)
            OP_ADD, OP_FIND, OP_REMOVE: begin
              mod_start = 1'b1;
              state_d   = S_MOD;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_MOD: begin
        if (mod_res.done) begin
          pos_d     = mod_res.rem;
          mem_raddr = IdxW'(mod_res.rem);
          state_d   = S_EVAL;
        end
      end

      S_EVAL: begin
        case (rd_mark)
          MARK_FILLED: begin
            if (rd_key == key_q) begin
              stop    = 1'b1;
              found_d = 1'b1;
              have_d  = 1'b1;
              slot_d  = pos_q;
            end
          end
          MARK_DELETED: begin
            if (!seen_q) begin
              seen_d = 1'b1;
              del_d  = pos_q;
            end
          end
          default: begin
            stop   = 1'b1;
            have_d = 1'b1;
            slot_d = seen_q ? del_q : pos_q;
          end
        endcase
        if (stop) begin
          state_d = S_DONE;
        end else if (probes_inc == n_eff) begin
          // All active slots walked: reuse the first deleted slot if any.
          have_d  = seen_d;
          slot_d  = del_d;
          state_d = S_DONE;
        end else begin
          probes_d  = probes_inc;
          pos_d     = pos_next;
          mem_raddr = IdxW'(pos_next);
        end
      end

      S_DONE: begin
        if (load_out) begin
          case (op_q)
            OP_ADD: begin
              if (count_q >= n_eff) begin
                res_full = 1'b1;
              end else if (!found_q && have_q) begin
                mem_we      = 1'b1;
                mem_wdata   = {MARK_FILLED, key_q};
                count_d     = count_q + 1'b1;
                res_changed = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (found_q) begin
                mem_we      = 1'b1;
                mem_wdata   = {MARK_DELETED, key_q};
                res_changed = 1'b1;
                if (count_q != '0) begin
                  count_d = count_q - 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
          out_valid_d   = 1'b1;
          out_found_d   = found_q;
          out_changed_d = res_changed;
          out_full_d    = res_full;
          out_count_d   = count_d;
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, request context and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      active_q      <= CountW'(256);
      count_q       <= '0;
      op_q          <= '0;
      key_q         <= '0;
      pos_q         <= '0;
      probes_q      <= '0;
      seen_q        <= 1'b0;
      del_q         <= '0;
      found_q       <= 1'b0;
      have_q        <= 1'b0;
      slot_q        <= '0;
      clr_q         <= '0;
      out_valid_q   <= 1'b0;
      out_found_q   <= 1'b0;
      out_changed_q <= 1'b0;
      out_full_q    <= 1'b0;
      out_count_q   <= '0;
    end else begin
      state_q       <= state_d;
      active_q      <= active_d;
      count_q       <= count_d;
      op_q          <= op_d;
      key_q         <= key_d;
      pos_q         <= pos_d;
      probes_q      <= probes_d;
      seen_q        <= seen_d;
      del_q         <= del_d;
      found_q       <= found_d;
      have_q        <= have_d;
      slot_q        <= slot_d;
      clr_q         <= clr_d;
      out_valid_q   <= out_valid_d;
      out_found_q   <= out_found_d;
      out_changed_q <= out_changed_d;
      out_full_q    <= out_full_d;
      out_count_q   <= out_count_d;
    end
  end

  // Slot memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = out_found_q;
  assign changed_o       = out_changed_q;
  assign table_full_o    = out_full_q;
  assign element_count_o = out_count_q;

  // The element count never passes the largest usable slot count.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Cap))
    else $error("element count above usable slot count");

  // The memory is only written by the clearing sweep or the write-back cycle.
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_DONE || state_q == S_CLEAR))
    else $error("slot memory written outside sweep or write-back");

  // A probe never walks more slots than are active.
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> (probes_q < n_eff))
    else $error("probe walked past the active slot count");

  // A request that reports a change moves the element count.
  a_changed_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && res_changed) |=> (count_q != $past(count_q)))
    else $error("table changed without a count update");

endmodule

[test/open_addressing_hash_set_checker.sv]
// Checker for the hash set: mirrors the slot table, predicts every result and compares it.
`timescale 1ns / 1ps
module open_addressing_hash_set_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ohs_pkg::CountW-1:0] cfg_slots_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [1:0]                 operation_i,
  input  logic [31:0]                key_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic                       found_i,
  input  logic                       changed_i,
  input  logic                       table_full_i,
  input  logic [ohs_pkg::CountW-1:0] element_count_i,
  output int                         errors_o,
  output int                         pending_o
);
  import ohs_pkg::*;

  localparam int unsigned TableSlots = 256;

  typedef struct packed {
    logic              found;
    logic              changed;
    logic              full;
    logic [CountW-1:0] count;
  } outcome_t;

  // Mirror of the block's table, count and active slot register.
  logic [1:0]        mark_q [TableSlots];
  logic [31:0]       key_q  [TableSlots];
  logic [CountW-1:0] filled_q;
  logic [CountW-1:0] slots_q;

  // Expected results in request order.
  outcome_t    outcomes_q [$];
  int unsigned results_seen = 0;
  int          mismatches   = 0;
  int          waiting      = 0;

  assign errors_o  = mismatches;
  assign pending_o = waiting;

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: result %0d: %s: got %0d, expected %0d", $time, results_seen, what,
             got, want);
    mismatches++;
  endtask

  // A zero register acts as one slot, and anything past the table acts as the whole table.
  function automatic int unsigned live_slots();
    if (slots_q == 0) return 1;
    if (slots_q > TableSlots) return TableSlots;
    return slots_q;
  endfunction

  // Linear probe from the home slot. Returns 1 on a hit with slot set to it; on a miss, slot
  // is where an add would go (first deleted slot seen, else the empty one that ended the walk).
  function automatic bit probe_key(input logic [31:0] key, input int unsigned n,
                                   output int unsigned slot, output bit have_slot);
    int unsigned pos;
    int unsigned del_pos;
    bit          seen_del;
    pos       = key % n;
    del_pos   = 0;
    seen_del  = 1'b0;
    slot      = 0;
    have_slot = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (mark_q[pos] == MARK_FILLED) begin
        if (key_q[pos] == key) begin
          slot      = pos;
          have_slot = 1'b1;
          return 1'b1;
        end
      end else if (mark_q[pos] == MARK_DELETED) begin
        if (!seen_del) begin
          seen_del = 1'b1;
          del_pos  = pos;
        end
      end else begin
        slot      = seen_del ? del_pos : pos;
        have_slot = 1'b1;
        return 1'b0;
      end
      pos = (pos + 1 >= n) ? 0 : pos + 1;
    end
    slot      = del_pos;
    have_slot = seen_del;
    return 1'b0;
  endfunction

  // Applies one request to the mirror and returns the result the block should give.
  function automatic outcome_t serve_request(input logic [1:0] op, input logic [31:0] key);
    outcome_t    res;
    int unsigned n;
    int unsigned slot;
    bit          have_slot;
    res       = '0;
    n         = live_slots();
    slot      = 0;
    have_slot = 1'b0;
    if (op == OP_ADD || op == OP_FIND || op == OP_REMOVE) begin
      res.found = probe_key(key, n, slot, have_slot);
    end
    if (op == OP_ADD) begin
      if (filled_q >= n) begin
        res.full = 1'b1;
      end else if (!res.found && have_slot) begin
        key_q[slot]  = key;
        mark_q[slot] = MARK_FILLED;
        filled_q++;
        res.changed = 1'b1;
      end
    end else if (op == OP_REMOVE) begin
      if (res.found) begin
        mark_q[slot] = MARK_DELETED;
        if (filled_q != 0) filled_q--;
        res.changed = 1'b1;
      end
    end
    res.count = filled_q;
    return res;
  endfunction

  // Watch both channels and the register port; results are checked before new requests
  // are predicted so that a premature result is never matched against its own request.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    outcome_t want;
    if (!rst_ni) begin
      foreach (mark_q[i]) mark_q[i] = MARK_EMPTY;
      foreach (key_q[i]) key_q[i] = '0;
      filled_q = '0;
      slots_q  = 9'd256;
      outcomes_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (outcomes_q.size() == 0) begin
          report_mismatch("result with no request pending", 1, 0);
        end else begin
          want = outcomes_q.pop_front();
          if (found_i !== want.found) report_mismatch("found", found_i, want.found);
          if (changed_i !== want.changed) report_mismatch("changed", changed_i, want.changed);
          if (table_full_i !== want.full) report_mismatch("table_full", table_full_i, want.full);
          if (element_count_i !== want.count) begin
            report_mismatch("element_count", element_count_i, want.count);
          end
        end
        results_seen++;
      end
      if (cfg_we_i) slots_q = cfg_slots_i;
      if (in_valid_i && in_ready_i) outcomes_q.push_back(serve_request(operation_i, key_i));
    end
    waiting = outcomes_q.size();
  end

endmodule

[test/open_addressing_hash_set_tb.sv]
// Testbench top for the hash set: drives requests and the slot register, and gives the verdict.
`timescale 1ns / 1ps
module open_addressing_hash_set_tb;
  import ohs_pkg::*;

  // Operation code that the block ignores.
  localparam logic [1:0]  OP_IGNORED     = 2'd3;
  localparam int unsigned MaxCycles      = 1_500_000;
  localparam int unsigned SettleCycles   = 16;
  localparam int unsigned DrainCycles    = 300;
  localparam int unsigned HoldCycles     = 400;
  localparam int unsigned HoldAfterItems = 45;
  localparam int unsigned PhaseItems     = 43;
  localparam int unsigned PoolDepth      = 48;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              slots_we_i  = 1'b0;
  logic [CountW-1:0] slots_i     = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [1:0]        operation_i = OP_FIND;
  logic [31:0]       key_i       = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              found_o;
  logic              changed_o;
  logic              table_full_o;
  logic [CountW-1:0] element_count_o;

  int          errors;
  int          pending;
  int unsigned sent        = 0;
  int unsigned cycle_count = 0;
  bit          quiet       = 1'b0;

  // Recently added keys, reused so that finds and removes hit.
  logic [31:0] added_keys [$];

  // Active slot settings for the random part, extremes included.
  int unsigned phase_plan [$] = '{8, 1, 3, 16, 2, 256, 0, 64, 511, 37, 255};

  always #10ns clk_i = ~clk_i;

  open_addressing_hash_set dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .active_slots_we_i(slots_we_i),
    .active_slots_i   (slots_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .key_i            (key_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .found_o          (found_o),
    .changed_o        (changed_o),
    .table_full_o     (table_full_o),
    .element_count_o  (element_count_o)
  );

  open_addressing_hash_set_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (slots_we_i),
    .cfg_slots_i    (slots_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .operation_i    (operation_i),
    .key_i          (key_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_i        (found_o),
    .changed_i      (changed_o),
    .table_full_i   (table_full_o),
    .element_count_i(element_count_o),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  // Keeps the request channel empty for a number of cycles.
  task automatic idle_cycles(input int unsigned count);
    repeat (count) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Offers one item, possibly after a random gap, and waits until it is accepted.
  task automatic send_request(input logic [1:0] op, input logic [31:0] key);
    if (!quiet && $urandom_range(0, 5) == 0) idle_cycles($urandom_range(1, 11));
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_i       <= key;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    if (op == OP_ADD) begin
      added_keys.push_back(key);
      if (added_keys.size() > PoolDepth) void'(added_keys.pop_front());
    end
  endtask

  // Writes the active slot register once every result is back and the block has settled.
  task automatic set_slots(input logic [CountW-1:0] value);
    idle_cycles(1);
    while (pending != 0) idle_cycles(1);
    idle_cycles(SettleCycles);
    @(negedge clk_i);
    slots_we_i <= 1'b1;
    slots_i    <= value;
    @(negedge clk_i);
    slots_we_i <= 1'b0;
  endtask

  // Mixes reused keys, keys that share a home slot, small keys and full-width keys.
  function automatic logic [31:0] pick_key(input int unsigned n);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35 && added_keys.size() != 0) begin
      return added_keys[$urandom_range(0, added_keys.size() - 1)];
    end
    if (r < 65) return $urandom_range(0, (n > 4) ? 3 : n - 1) + n * $urandom_range(0, 1000);
    if (r < 85) return $urandom_range(0, 2 * n);
    return $urandom();
  endfunction

  // One random phase at a given active slot setting.
  task automatic run_phase(input logic [CountW-1:0] setting, input int unsigned items);
    int unsigned n;
    int unsigned r;
    logic [1:0]  op;
    set_slots(setting);
    n = (setting == 0) ? 1 : ((setting > 256) ? 256 : setting);
    repeat (items) begin
      r = $urandom_range(0, 99);
      if (r < 40) op = OP_ADD;
      else if (r < 65) op = OP_FIND;
      else if (r < 95) op = OP_REMOVE;
      else op = OP_IGNORED;
      send_request(op, pick_key(n));
    end
  endtask

  // Result side: random stalls, plus one long hold-off so the block backs up its input.
  initial begin : receiver
    int unsigned stall;
    bit          held;
    stall = 0;
    held  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else if (!held && sent >= HoldAfterItems) begin
        held        = 1'b1;
        stall       = HoldCycles - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall       = $urandom_range(1, 11) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Run limit.
  initial begin : watchdog
    while (cycle_count < MaxCycles) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[open_addressing_hash_set] ERROR");
    $finish;
  end

  // Stimulus and verdict.
  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting of 256 slots: empty table, collisions at slot zero, extreme keys.
    send_request(OP_FIND, 32'd0);
    send_request(OP_ADD, 32'd0);
    send_request(OP_ADD, 32'd256);
    send_request(OP_ADD, 32'hFFFF_FFFF);
    send_request(OP_ADD, 32'd0);
    send_request(OP_FIND, 32'd256);
    send_request(OP_REMOVE, 32'd0);
    // The probe for 256 walks over the deleted slot.
    send_request(OP_FIND, 32'd256);
    send_request(OP_REMOVE, 32'd0);
    // The add reuses the deleted slot.
    send_request(OP_ADD, 32'd512);
    send_request(OP_IGNORED, 32'hFFFF_FFFF);

    // Shrink to four slots while keys are stored; one key now lies past the active slots.
    set_slots(9'd4);
    send_request(OP_ADD, 32'd3);
    send_request(OP_ADD, 32'd7);
    send_request(OP_ADD, 32'd512);
    send_request(OP_FIND, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 32'd256);
    send_request(OP_ADD, 32'd4);

    // A zero setting acts as a single slot.
    set_slots(9'd0);
    send_request(OP_ADD, 32'd9);
    send_request(OP_FIND, 32'd512);
    send_request(OP_REMOVE, 32'd512);
    send_request(OP_FIND, 32'd5);

    // A setting past the table acts as the whole table.
    set_slots(9'd511);
    send_request(OP_ADD, 32'h8000_0000);
    send_request(OP_FIND, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 32'hFFFF_FFFF);
    send_request(OP_ADD, 32'h5555_AAAA);

    // Random phases; the last one runs without idling on either side.
    foreach (phase_plan[p]) begin
      if (p == phase_plan.size() - 1) quiet = 1'b1;
      run_phase(phase_plan[p][CountW-1:0], PhaseItems);
    end

    idle_cycles(1);
    while (pending != 0) idle_cycles(1);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[open_addressing_hash_set] OK");
    end else begin
      $display("[open_addressing_hash_set] ERROR");
    end
    $finish;
  end

endmodule
